// ----- rtl/vrp_pkg.sv -----
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types and constants of the vertex rotate / project pipeline.
// ----------------------------------------------------------------------------
package vrp_pkg;

    localparam int CW               = 16;      // vertex coordinate width, Qn.12
    localparam int SINE_TABLE_DEPTH = 1024;    // default quarter-wave table depth
    localparam int TRIG_W           = 16;      // signed Q1.14 sine / cosine
    localparam int R1W              = CW + 1;  // after first rotation
    localparam int R2W              = CW + 2;  // after second rotation
    localparam int DW               = ((R2W > 17) ? R2W : 17) + 1;  // z + distance
    localparam int NUMW             = R2W + 13;                     // rotated * focal
    localparam int MW               = NUMW - 1 + 4;                 // |numerator| * 16
    localparam int NW               = MW + 1;                       // plus d / 2
    localparam int QW               = 20;                           // quotient bits
    localparam int SW               = (NW > DW - 1 + QW) ? NW : DW - 1 + QW;
    localparam int OUT_W            = 20;

    localparam logic [12:0] FULL_TURN    = 13'd5760;
    localparam logic [12:0] QUARTER_TURN = 13'd1440;
    localparam logic [23:0] HALF_QUARTER = 24'd720;
    localparam logic [18:0] RECIP_45     = 19'd372828;  // ceil(2^24 / 45)
    localparam int          RECIP_SHIFT  = 24;

    typedef enum logic [1:0] {
        REG_FOCAL_SCALE     = 2'd0,
        REG_CAMERA_DISTANCE = 2'd1,
        REG_SCREEN_WIDTH    = 2'd2,
        REG_SCREEN_HEIGHT   = 2'd3
    } cfg_reg_e;

    typedef struct packed {
        logic        [12:0]   rot_angle;
        logic signed [CW-1:0] vertex_x;
        logic signed [CW-1:0] vertex_y;
        logic signed [CW-1:0] vertex_z;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] screen_x;
        logic signed [OUT_W-1:0] screen_y;
        logic                    behind_camera;
    } out_item_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } vtx_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin;
        logic signed [TRIG_W-1:0] cos;
        vtx_t                     vtx;
    } trig_out_t;

    typedef struct packed {
        logic signed [R1W-1:0] xr;
        logic signed [R2W-1:0] yr;
        logic signed [R2W-1:0] zr;
    } rot_out_t;

    typedef struct packed {
        logic [DW-2:0]          dvsr;
        logic [1:0][NW-1:0]     dvnd;
        logic [1:0]             neg;
        logic [1:0]             sat;
        logic                   behind;
    } div_in_t;

    typedef struct packed {
        logic [1:0][QW-1:0]     quo;
        logic [1:0]             neg;
        logic [1:0]             sat;
        logic                   behind;
    } div_out_t;

endpackage

// ----- rtl/vrp_trig.sv -----
// ----------------------------------------------------------------------------
// vrp_trig
// Angle reduction, table index and quarter-wave sine / cosine lookup.
// Five stages; the vertex rides along unchanged.
// ----------------------------------------------------------------------------
module vrp_trig #(
    parameter int SINE_TABLE_DEPTH = vrp_pkg::SINE_TABLE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  vrp_pkg::in_item_t   in_item,
    output logic                out_valid,
    output vrp_pkg::trig_out_t  out_data
);

    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam longint unsigned HalfPiQ30 = 64'd1686629713;

    typedef logic [14:0] rom_t [0:SINE_TABLE_DEPTH];

    // round(16384 * sin(pi/2 * i / depth)) from a Q30 Taylor series
    function automatic rom_t build_rom();
        rom_t              tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        longint            v;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = (HalfPiQ30 * longint'(i)) / SINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
            term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
            term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
            term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
            term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
            term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
            if (sum < 0) begin
                sum = 0;
            end
            v = (sum + 32768) >>> 16;
            if (v > 16384) begin
                v = 16384;
            end
            tab[i] = 15'(v);
        end
        return tab;
    endfunction

    localparam rom_t SineRom = build_rom();

    logic [4:0]      vld_reg;
    vrp_pkg::vtx_t   vtx1_reg, vtx2_reg, vtx3_reg, vtx4_reg;
    logic [1:0]      quad1_reg, quad2_reg, quad3_reg, quad4_reg;
    logic [10:0]     rem_reg;
    logic [18:0]     n5_reg;
    logic [IW-1:0]   idx_reg;
    logic [14:0]     rom_a_reg, rom_b_reg;
    vrp_pkg::trig_out_t out_reg;

    logic [12:0]     a_red;
    logic [1:0]      quad_next;
    logic [10:0]     rem_next;
    logic [23:0]     n_full;
    logic [37:0]     prod;
    logic [13:0]     idx_full;
    logic [IW-1:0]   idx_next;
    logic [14:0]     sin_mag, cos_mag;
    logic            sin_neg, cos_neg;
    vrp_pkg::trig_out_t out_next;

    // stage 1: reduce to one turn and split into quadrant and remainder
    always_comb begin
        a_red = (in_item.rot_angle >= vrp_pkg::FULL_TURN) ?
                in_item.rot_angle - vrp_pkg::FULL_TURN : in_item.rot_angle;
        if (a_red < vrp_pkg::QUARTER_TURN) begin
            quad_next = 2'd0;
            rem_next  = 11'(a_red);
        end else if (a_red < 13'(2 * 1440)) begin
            quad_next = 2'd1;
            rem_next  = 11'(a_red - vrp_pkg::QUARTER_TURN);
        end else if (a_red < 13'(3 * 1440)) begin
            quad_next = 2'd2;
            rem_next  = 11'(a_red - 13'(2 * 1440));
        end else begin
            quad_next = 2'd3;
            rem_next  = 11'(a_red - 13'(3 * 1440));
        end
    end

    // stages 2-3: idx = (rem*depth + 720) / 1440 = ((..) >> 5) / 45
    always_comb begin
        n_full   = 24'(rem_reg) * 24'(SINE_TABLE_DEPTH) + vrp_pkg::HALF_QUARTER;
        prod     = 38'(n5_reg) * 38'(vrp_pkg::RECIP_45);
        idx_full = prod[vrp_pkg::RECIP_SHIFT +: 14];
        idx_next = (idx_full > 14'(SINE_TABLE_DEPTH)) ?
                   IW'(SINE_TABLE_DEPTH) : IW'(idx_full);
    end

    // stage 5: cosine is the sine one quadrant later
    always_comb begin
        sin_mag = quad4_reg[0] ? rom_b_reg : rom_a_reg;
        cos_mag = quad4_reg[0] ? rom_a_reg : rom_b_reg;
        sin_neg = quad4_reg[1];
        cos_neg = (quad4_reg == 2'd1) || (quad4_reg == 2'd2);
        out_next.sin = sin_neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
        out_next.cos = cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
        out_next.vtx = vtx4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vtx1_reg  <= '{x: in_item.vertex_x, y: in_item.vertex_y, z: in_item.vertex_z};
            quad1_reg <= quad_next;
            rem_reg   <= rem_next;
            vtx2_reg  <= vtx1_reg;
            quad2_reg <= quad1_reg;
            n5_reg    <= n_full[23:5];
            vtx3_reg  <= vtx2_reg;
            quad3_reg <= quad2_reg;
            idx_reg   <= idx_next;
            vtx4_reg  <= vtx3_reg;
            quad4_reg <= quad3_reg;
            rom_a_reg <= SineRom[idx_reg];
            rom_b_reg <= SineRom[IW'(SINE_TABLE_DEPTH) - idx_reg];
            out_reg   <= out_next;
        end
    end

    assign out_valid = vld_reg[4];
    assign out_data  = out_reg;

endmodule

// ----- rtl/vrp_rotate.sv -----
// ----------------------------------------------------------------------------
// vrp_rotate
// Rotation about Y then X: multiply stage, round stage, twice over.
// ----------------------------------------------------------------------------
module vrp_rotate (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  vrp_pkg::trig_out_t  in_data,
    output logic                out_valid,
    output vrp_pkg::rot_out_t   out_data
);

    localparam int PW1 = vrp_pkg::CW + vrp_pkg::TRIG_W;
    localparam int PW2 = vrp_pkg::R1W + vrp_pkg::TRIG_W;
    localparam int SW1 = PW1 + 2;
    localparam int SW2 = PW2 + 2;

    logic [3:0] vld_reg;

    logic signed [PW1-1:0] xc_reg, zs_reg, xs_reg, zc_reg;
    logic signed [vrp_pkg::CW-1:0]     y1_reg, y2_reg;
    logic signed [vrp_pkg::TRIG_W-1:0] s1_reg, c1_reg, s2_reg, c2_reg;
    logic signed [vrp_pkg::R1W-1:0]    xr2_reg, z1_reg, xr3_reg;
    logic signed [PW2-1:0] yc_reg, z1s_reg, ys_reg, z1c_reg;
    vrp_pkg::rot_out_t     out_reg;

    logic signed [SW1-1:0] xr_sum, z1_sum;
    logic signed [SW2-1:0] yr_sum, zr_sum;

    // round half up to Q12: (v + 2^13) >> 14, floor
    always_comb begin
        xr_sum = SW1'(xc_reg) - SW1'(zs_reg) + SW1'(8192);
        z1_sum = SW1'(xs_reg) + SW1'(zc_reg) + SW1'(8192);
        yr_sum = SW2'(yc_reg) - SW2'(z1s_reg) + SW2'(8192);
        zr_sum = SW2'(ys_reg) + SW2'(z1c_reg) + SW2'(8192);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xc_reg  <= in_data.vtx.x * in_data.cos;
            zs_reg  <= in_data.vtx.z * in_data.sin;
            xs_reg  <= in_data.vtx.x * in_data.sin;
            zc_reg  <= in_data.vtx.z * in_data.cos;
            y1_reg  <= in_data.vtx.y;
            s1_reg  <= in_data.sin;
            c1_reg  <= in_data.cos;

            xr2_reg <= vrp_pkg::R1W'(xr_sum >>> 14);
            z1_reg  <= vrp_pkg::R1W'(z1_sum >>> 14);
            y2_reg  <= y1_reg;
            s2_reg  <= s1_reg;
            c2_reg  <= c1_reg;

            yc_reg  <= y2_reg * c2_reg;
            z1s_reg <= z1_reg * s2_reg;
            ys_reg  <= y2_reg * s2_reg;
            z1c_reg <= z1_reg * c2_reg;
            xr3_reg <= xr2_reg;

            out_reg.xr <= xr3_reg;
            out_reg.yr <= vrp_pkg::R2W'(yr_sum >>> 14);
            out_reg.zr <= vrp_pkg::R2W'(zr_sum >>> 14);
        end
    end

    assign out_valid = vld_reg[3];
    assign out_data  = out_reg;

endmodule

// ----- rtl/vrp_div.sv -----
// ----------------------------------------------------------------------------
// vrp_div
// Two-lane restoring divider, one quotient bit per stage.
// Dividends known to overflow the quotient arrive flagged and ride along.
// ----------------------------------------------------------------------------
module vrp_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  vrp_pkg::div_in_t  in_data,
    output logic              out_valid,
    output vrp_pkg::div_out_t out_data
);

    localparam int QW = vrp_pkg::QW;
    localparam int NW = vrp_pkg::NW;
    localparam int SW = vrp_pkg::SW;

    typedef struct packed {
        logic [vrp_pkg::DW-2:0] dvsr;
        logic [1:0][NW-1:0]     rem;
        logic [1:0][QW-1:0]     quo;
        logic [1:0]             neg;
        logic [1:0]             sat;
        logic                   behind;
    } stage_t;

    logic [QW-1:0] vld_reg;
    stage_t        stg_reg [QW];
    stage_t        src     [QW];
    stage_t        nxt     [QW];

    always_comb begin
        src[0].dvsr   = in_data.dvsr;
        src[0].rem    = in_data.dvnd;
        src[0].quo    = '0;
        src[0].neg    = in_data.neg;
        src[0].sat    = in_data.sat;
        src[0].behind = in_data.behind;
        for (int k = 1; k < QW; k++) begin
            src[k] = stg_reg[k-1];
        end
    end

    // stage k decides quotient bit QW-1-k
    always_comb begin
        logic [SW-1:0] dsh;
        for (int k = 0; k < QW; k++) begin
            nxt[k] = src[k];
            dsh    = SW'(src[k].dvsr) << (QW - 1 - k);
            for (int l = 0; l < 2; l++) begin
                if (SW'(src[k].rem[l]) >= dsh) begin
                    nxt[k].rem[l]            = NW'(SW'(src[k].rem[l]) - dsh);
                    nxt[k].quo[l][QW-1-k]    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QW-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < QW; k++) begin
                stg_reg[k] <= nxt[k];
            end
        end
    end

    assign out_valid       = vld_reg[QW-1];
    assign out_data.quo    = stg_reg[QW-1].quo;
    assign out_data.neg    = stg_reg[QW-1].neg;
    assign out_data.sat    = stg_reg[QW-1].sat;
    assign out_data.behind = stg_reg[QW-1].behind;

endmodule

// ----- rtl/vertex_rotate_project_core.sv -----
// ----------------------------------------------------------------------------
// vertex_rotate_project_core
// Rotates a vertex about Y then X and projects it to signed Q16.4 screen
// coordinates with a perspective divide.
// ----------------------------------------------------------------------------
// One request in and one result out per clock while no finished result waits on
// m_ready. A request passes through angle reduction and sine/cosine table lookup,
// the two rotations, the divisor and numerators, the one-bit-per-stage divider
// and offset and saturation, in that order. The whole pipeline holds while a
// finished result is not taken, so s_ready follows m_ready combinationally
// whenever m_valid is high. Configuration registers are read by the stages
// that use them and should only be written while no request is in flight.
module vertex_rotate_project_core #(
    parameter int SINE_TABLE_DEPTH = vrp_pkg::SINE_TABLE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vrp_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output vrp_pkg::out_item_t  m_data,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam int DW    = vrp_pkg::DW;
    localparam int NUMW  = vrp_pkg::NUMW;
    localparam int MW    = vrp_pkg::MW;
    localparam int NW    = vrp_pkg::NW;
    localparam int SW    = vrp_pkg::SW;
    localparam int QW    = vrp_pkg::QW;
    localparam int RW    = QW + 2;
    localparam int OUT_W = vrp_pkg::OUT_W;

    logic        adv;
    logic [11:0] focal_reg;
    logic [15:0] cam_dist_reg;
    logic [12:0] scr_w_reg;
    logic [12:0] scr_h_reg;

    logic                trig_valid;
    vrp_pkg::trig_out_t  trig_data;
    logic                rot_valid;
    vrp_pkg::rot_out_t   rot_data;
    logic                div_valid;
    vrp_pkg::div_out_t   div_data;

    logic                   p1_vld_reg;
    logic signed [DW-1:0]   d_reg;
    logic                   behind1_reg;
    logic signed [NUMW-1:0] numx_reg, numy_reg;
    logic                   p2_vld_reg;
    vrp_pkg::div_in_t       div_in_reg;

    logic                   m_valid_reg;
    vrp_pkg::out_item_t     m_data_reg;

    logic signed [DW-1:0]   d_next;
    vrp_pkg::div_in_t       div_in_next;
    vrp_pkg::out_item_t     m_data_next;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_reg    <= 12'd500;
            cam_dist_reg <= 16'd14336;
            scr_w_reg    <= 13'd1920;
            scr_h_reg    <= 13'd1080;
        end else if (cfg_wr_en) begin
            case (vrp_pkg::cfg_reg_e'(cfg_index))
                vrp_pkg::REG_FOCAL_SCALE:     focal_reg    <= cfg_data[11:0];
                vrp_pkg::REG_CAMERA_DISTANCE: cam_dist_reg <= cfg_data;
                vrp_pkg::REG_SCREEN_WIDTH:    scr_w_reg    <= cfg_data[12:0];
                vrp_pkg::REG_SCREEN_HEIGHT:   scr_h_reg    <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    vrp_trig #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_trig (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_valid),
        .in_item   (s_data),
        .out_valid (trig_valid),
        .out_data  (trig_data)
    );

    vrp_rotate u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (trig_valid),
        .in_data   (trig_data),
        .out_valid (rot_valid),
        .out_data  (rot_data)
    );

    // divisor and numerators
    assign d_next = DW'(rot_data.zr) + DW'($signed({1'b0, cam_dist_reg}));

    // magnitudes, round-to-nearest bias and quotient overflow check
    always_comb begin
        logic [NUMW-2:0] magx, magy;
        logic [MW-1:0]   m16x, m16y;
        magx = numx_reg[NUMW-1] ? (NUMW-1)'(-numx_reg) : numx_reg[NUMW-2:0];
        magy = numy_reg[NUMW-1] ? (NUMW-1)'(-numy_reg) : numy_reg[NUMW-2:0];
        m16x = {magx, 4'b0000};
        m16y = {magy, 4'b0000};
        div_in_next.dvsr    = d_reg[DW-2:0];
        div_in_next.dvnd[0] = NW'(m16x) + NW'(d_reg[DW-2:1]);
        div_in_next.dvnd[1] = NW'(m16y) + NW'(d_reg[DW-2:1]);
        div_in_next.neg     = {numy_reg[NUMW-1], numx_reg[NUMW-1]};
        for (int l = 0; l < 2; l++) begin
            div_in_next.sat[l] = SW'(div_in_next.dvnd[l]) >= (SW'(d_reg[DW-2:0]) << QW);
        end
        div_in_next.behind  = behind1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end else if (adv) begin
            p1_vld_reg <= rot_valid;
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg       <= d_next;
            behind1_reg <= d_next[DW-1] || (d_next == '0);
            numx_reg    <= rot_data.xr * $signed({1'b0, focal_reg});
            numy_reg    <= rot_data.yr * $signed({1'b0, focal_reg});
            div_in_reg  <= div_in_next;
        end
    end

    vrp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (p2_vld_reg),
        .in_data   (div_in_reg),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    function automatic logic [OUT_W-1:0] finish(input logic [QW-1:0] quo, input logic neg,
                                                input logic sat, input logic [12:0] size);
        logic [QW-1:0]        q;
        logic signed [RW-1:0] v;
        q = sat ? '1 : quo;
        v = neg ? -$signed(RW'(q)) : $signed(RW'(q));
        v = v + $signed(RW'({size, 3'b000}));
        if (v > $signed(RW'((1 << (OUT_W - 1)) - 1))) begin
            v = $signed(RW'((1 << (OUT_W - 1)) - 1));
        end else if (v < -$signed(RW'(1 << (OUT_W - 1)))) begin
            v = -$signed(RW'(1 << (OUT_W - 1)));
        end
        return v[OUT_W-1:0];
    endfunction

    always_comb begin
        m_data_next.behind_camera = div_data.behind;
        if (div_data.behind) begin
            m_data_next.screen_x = '0;
            m_data_next.screen_y = '0;
        end else begin
            m_data_next.screen_x = finish(div_data.quo[0], div_data.neg[0],
                                          div_data.sat[0], scr_w_reg);
            m_data_next.screen_y = finish(div_data.quo[1], div_data.neg[1],
                                          div_data.sat[1], scr_h_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_behind_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.behind_camera) |->
        (m_data_reg.screen_x == '0 && m_data_reg.screen_y == '0))
        else $error("behind_camera result with nonzero coordinates");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("result valid right after reset");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(div_valid))
        else $error("result appeared without a divider output");

endmodule

// ----- tb/tb_vertex_rotate_project_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_rotate_project_core
// Streams vertices through the rotate / project pipeline under several
// register settings and random stalls on both channels. Every result is
// compared in order to a set value or the bench's bit-true projection model.
// ----------------------------------------------------------------------------
module tb_vertex_rotate_project_core;

    localparam int TAB_DEPTH  = 1024;
    localparam int DRAIN_CYC  = 40;      // pipeline is 32 deep
    localparam int CYCLE_CAP  = 300000;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    vrp_pkg::in_item_t   s_data;
    logic                m_valid;
    logic                m_ready;
    vrp_pkg::out_item_t  m_data;
    logic                cfg_wr_en;
    logic [1:0]          cfg_index;
    logic [15:0]         cfg_data;

    vertex_rotate_project_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    typedef struct {
        vrp_pkg::in_item_t  req;
        bit                 typed;
        vrp_pkg::out_item_t want;
    } vec_row_t;

    int                 sine_q14 [0:TAB_DEPTH];
    int                 focal_sh, dist_sh, width_sh, height_sh;
    vrp_pkg::out_item_t screen_q [$];
    int                 send_idle, recv_idle;
    int                 cycles;
    bit                 failed;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // quarter-wave table, Q30 Taylor series rounded to Q1.14
    task automatic build_sine();
        longint unsigned xv, x2, term;
        longint sum, v;
        for (int i = 0; i <= TAB_DEPTH; i++) begin
            xv = (64'd1686629713 * i) / TAB_DEPTH;
            x2 = (xv * xv) >> 30;
            term = xv;
            sum = xv;
            for (int k = 1; k <= 6; k++) begin
                term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
                if (k % 2) sum -= term;
                else sum += term;
            end
            if (sum < 0) sum = 0;
            v = (sum + 32768) >>> 16;
            if (v > 16384) v = 16384;
            sine_q14[i] = v;
        end
    endtask

    function automatic longint sine_at(int a);
        int q, r, idx;
        longint v;
        q = (a / 1440) % 4;
        r = a % 1440;
        idx = (r * TAB_DEPTH + 720) / 1440;
        if (idx > TAB_DEPTH) idx = TAB_DEPTH;
        v = (q % 2) ? sine_q14[TAB_DEPTH - idx] : sine_q14[idx];
        return (q >= 2) ? -v : v;
    endfunction

    function automatic longint rnd_q14(longint v);
        return (v + 8192) >>> 14;
    endfunction

    function automatic longint to_screen(longint num, longint d, int size);
        longint mag, quo;
        mag = (num < 0) ? -num : num;
        quo = (mag + d / 2) / d;
        quo = (num < 0) ? -quo : quo;
        quo += size * 8;
        if (quo > 524287) quo = 524287;
        if (quo < -524288) quo = -524288;
        return quo;
    endfunction

    function automatic vrp_pkg::out_item_t project_vertex(vrp_pkg::in_item_t r);
        vrp_pkg::out_item_t o;
        int a;
        longint s, c, x, y, z, xr, z1, yr, zr, d, sx, sy;
        a = r.rot_angle;
        if (a >= 5760) a -= 5760;
        s = sine_at(a);
        c = sine_at((a + 1440) % 5760);
        x = r.vertex_x;
        y = r.vertex_y;
        z = r.vertex_z;
        xr = rnd_q14(x * c - z * s);
        z1 = rnd_q14(x * s + z * c);
        yr = rnd_q14(y * c - z1 * s);
        zr = rnd_q14(y * s + z1 * c);
        d = zr + dist_sh;
        o = '0;
        if (d <= 0) begin
            o.behind_camera = 1'b1;
        end else begin
            sx = to_screen(xr * focal_sh * 16, d, width_sh);
            sy = to_screen(yr * focal_sh * 16, d, height_sh);
            o.screen_x = sx[19:0];
            o.screen_y = sy[19:0];
        end
        return o;
    endfunction

    // entered and left at a falling edge; enable stays high for the caller to drop
    task automatic write_reg(vrp_pkg::cfg_reg_e idx, int val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[15:0];
        case (idx)
            vrp_pkg::REG_FOCAL_SCALE:     focal_sh  = val & 12'hFFF;
            vrp_pkg::REG_CAMERA_DISTANCE: dist_sh   = val & 16'hFFFF;
            vrp_pkg::REG_SCREEN_WIDTH:    width_sh  = val & 13'h1FFF;
            vrp_pkg::REG_SCREEN_HEIGHT:   height_sh = val & 13'h1FFF;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic set_regs(int f, int d, int w, int h);
        write_reg(vrp_pkg::REG_FOCAL_SCALE, f);
        write_reg(vrp_pkg::REG_CAMERA_DISTANCE, d);
        write_reg(vrp_pkg::REG_SCREEN_WIDTH, w);
        write_reg(vrp_pkg::REG_SCREEN_HEIGHT, h);
        cfg_wr_en <= 1'b0;
    endtask

    // entered and left at a falling edge
    task automatic send_req(vrp_pkg::in_item_t r, bit typed, vrp_pkg::out_item_t want);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        screen_q.push_back(typed ? want : project_vertex(r));
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (screen_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYC) @(negedge aclk);
    endtask

    function automatic vrp_pkg::in_item_t rand_vertex();
        vrp_pkg::in_item_t r;
        r.rot_angle = 13'($urandom_range(8191));
        if ($urandom_range(1)) begin
            r.vertex_x = 16'($urandom);
            r.vertex_y = 16'($urandom);
            r.vertex_z = 16'($urandom);
        end else begin
            r.vertex_x = 16'($urandom_range(16383) - 8192);
            r.vertex_y = 16'($urandom_range(16383) - 8192);
            r.vertex_z = 16'($urandom_range(16383) - 8192);
        end
        return r;
    endfunction

    task automatic random_burst(int n);
        for (int i = 0; i < n; i++) send_req(rand_vertex(), 1'b0, '0);
    endtask

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge aclk) begin
        vrp_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (screen_q.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d behind=%0b", $time,
                         m_data.screen_x, m_data.screen_y, m_data.behind_camera);
                failed = 1'b1;
            end else begin
                want = screen_q.pop_front();
                if (m_data.screen_x !== want.screen_x) begin
                    $display("%0t: screen_x expected %0d got %0d", $time,
                             want.screen_x, m_data.screen_x);
                    failed = 1'b1;
                end
                if (m_data.screen_y !== want.screen_y) begin
                    $display("%0t: screen_y expected %0d got %0d", $time,
                             want.screen_y, m_data.screen_y);
                    failed = 1'b1;
                end
                if (m_data.behind_camera !== want.behind_camera) begin
                    $display("%0t: behind_camera expected %0b got %0b", $time,
                             want.behind_camera, m_data.behind_camera);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        vec_row_t vecs [$];
        vec_row_t row;
        vrp_pkg::out_item_t centre, behind;
        int angles [8];

        angles = '{0, 1439, 1440, 2880, 4320, 5759, 5760, 8191};
        cycles = 0;
        failed = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = vrp_pkg::REG_FOCAL_SCALE;
        cfg_data = '0;
        focal_sh = 500;
        dist_sh = 14336;
        width_sh = 1920;
        height_sh = 1080;
        build_sine();

        centre = '{screen_x: 20'sd15360, screen_y: 20'sd8640, behind_camera: 1'b0};
        behind = '{screen_x: 20'sd0, screen_y: 20'sd0, behind_camera: 1'b1};
        // origin lands on screen center; zero angle with z at -8 is behind camera
        row = '{'{13'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, centre};    vecs.push_back(row);
        row = '{'{13'd5760, 16'sd0, 16'sd0, 16'sd0}, 1'b1, centre}; vecs.push_back(row);
        row = '{'{13'd0, 16'sd0, 16'sd0, -16'sd32768}, 1'b1, behind}; vecs.push_back(row);
        row = '{'{13'd5760, 16'sd0, 16'sd0, -16'sd32768}, 1'b1, behind}; vecs.push_back(row);
        foreach (angles[i]) begin
            row = '{'{angles[i][12:0], 16'sd32767, -16'sd32768, 16'sd4096}, 1'b0, '0};
            vecs.push_back(row);
            row = '{'{angles[i][12:0], -16'sd32768, 16'sd32767, 16'sd32767}, 1'b0, '0};
            vecs.push_back(row);
        end
        // near the camera plane: large projections, saturation
        row = '{'{13'd0, 16'sd32767, -16'sd32768, -16'sd14335}, 1'b0, '0};
        vecs.push_back(row);
        row = '{'{13'd0, -16'sd32768, 16'sd32767, -16'sd14335}, 1'b0, '0};
        vecs.push_back(row);

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        send_idle = 7;
        recv_idle = 65;
        foreach (vecs[i]) send_req(vecs[i].req, vecs[i].typed, vecs[i].want);
        random_burst(100);
        drain();

        set_regs(4095, 0, 4096, 4096);
        random_burst(150);
        drain();

        send_idle = 65;
        recv_idle = 7;
        set_regs(1, 65535, 1, 1);
        random_burst(120);
        drain();

        // zero focal scale and screen sizes past the legal range
        set_regs(0, 4096, 8191, 8191);
        random_burst(100);
        drain();

        send_idle = 0;
        recv_idle = 0;
        for (int p = 0; p < 4; p++) begin
            set_regs($urandom_range(4095), $urandom_range(65535),
                     $urandom_range(8191), $urandom_range(8191));
            random_burst(80);
            drain();
            random_burst(60);
            drain();
        end

        if (!failed) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
